>>> sv/assert_macros.svh
// Assertion macros shared by the beta core RTL.
// Depends on nothing; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property checked at every clock edge outside reset
`define NCB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must be followed by another one in the next cycle
`define NCB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define NCB_ASSERT(label, clk, rst_n, prop, msg)
`define NCB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> sv/ncb_pkg.sv
// Shared types, widths, register codes and the color distance function
// for the neighbor contrast beta core. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ncb_pkg;

    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;
    localparam int DIM_W      = 12;
    localparam int SUM_W      = 48;
    localparam int BETA_W     = 48;
    localparam int DIST_W     = 18;          // 3 * 255^2 fits
    localparam int ADD_W      = DIST_W + 2;  // four distances per pixel
    localparam int NUM_W      = 2 * DIM_W + 2;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam int MAX_HEIGHT        = 2048;
    localparam int DEF_MAX_WIDTH     = 2048;
    localparam int DEF_FRACTION_BITS = 32;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 12'd480;

    // Register index, taken from address bit 2
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0] t_pixel;

    typedef struct packed {
        logic             valid;
        logic [SUM_W-1:0] sum;
    } t_frame_done;

    typedef struct packed {
        logic [BETA_W-1:0] beta;
        logic [SUM_W-1:0]  sum;
        logic              sat;
    } t_result;

    typedef struct packed {
        logic    idle;
        logic    done;
        t_result result;
    } t_div_status;

    // Squared color distance over the three channels
    function automatic logic [DIST_W-1:0] sq_dist(t_pixel a, t_pixel b);
        logic signed [CH_W:0]     d;
        logic signed [2*CH_W+1:0] p;
        logic [DIST_W-1:0]        s;
        s = '0;
        for (int k = 0; k < 3; k++) begin
            d = $signed({1'b0, a[k*CH_W +: CH_W]}) - $signed({1'b0, b[k*CH_W +: CH_W]});
            p = (2*CH_W+2)'(d) * (2*CH_W+2)'(d);
            s = s + DIST_W'($unsigned(p));
        end
        return s;
    endfunction

endpackage

`default_nettype wire

>>> sv/ncb_if.sv
// Pixel and result channel interfaces (valid/ready) of the beta core.
// Depends on ncb_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ncb_pix_if;
    import ncb_pkg::*;
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] channel_0;
    logic [CH_W-1:0] channel_1;
    logic [CH_W-1:0] channel_2;

    modport source (output valid, output channel_0, output channel_1, output channel_2,
                    input ready);
    modport sink   (input valid, input channel_0, input channel_1, input channel_2,
                    output ready);
endinterface

interface ncb_res_if;
    import ncb_pkg::*;
    logic              valid;
    logic              ready;
    logic [BETA_W-1:0] beta_value;
    logic [SUM_W-1:0]  difference_sum;
    logic              beta_saturated;

    modport source (output valid, output beta_value, output difference_sum,
                    output beta_saturated, input ready);
    modport sink   (input valid, input beta_value, input difference_sum,
                    input beta_saturated, output ready);
endinterface

`default_nettype wire

>>> sv/ncb_front.sv
// Pixel front end: line buffer memory, raster counters, neighbor distances
// and the running difference sum. Depends on ncb_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ncb_front #(
    parameter int MAX_WIDTH = ncb_pkg::DEF_MAX_WIDTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_restart,
    input  logic [ncb_pkg::DIM_W-1:0] i_width,
    input  logic [ncb_pkg::DIM_W-1:0] i_height,
    input  logic                      i_accept,
    input  ncb_pkg::t_pixel           i_pix,
    output ncb_pkg::t_frame_done      o_done,
    output logic                      o_busy
);
    import ncb_pkg::*;

    localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int CMP_W = ((COL_W > DIM_W) ? COL_W : DIM_W) + 1;

    // line buffer, one entry per column of the previous row
    t_pixel r_mem [MAX_WIDTH];
    t_pixel r_rd_a;
    t_pixel r_rd_b;

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    t_pixel           r_left, n_left;
    t_pixel           r_upleft, n_upleft;
    t_pixel           r_up_q, n_up_q;
    t_pixel           r_ur_q, n_ur_q;
    logic             r_up_mem, n_up_mem;
    logic             r_ur_mem, n_ur_mem;

    logic             r_add_v;
    logic             r_add_last;
    logic [ADD_W-1:0] r_add;
    logic [SUM_W-1:0] r_sum;
    logic             r_done_v;
    logic [SUM_W-1:0] r_done_sum;

    t_pixel           cur_up;
    t_pixel           cur_ur;
    logic             has_up;
    logic             has_left;
    logic             has_right;
    logic             last_row;
    logic             width_is_1;
    logic             width_is_2;
    logic [ADD_W-1:0] add_c;
    logic [COL_W-1:0] rd_a_addr;
    logic             rd_b_en;
    logic [SUM_W-1:0] sum_next;

    // position in the frame
    assign has_up     = (r_row != '0);
    assign has_left   = (r_col != '0);
    assign has_right  = (CMP_W'(r_col) + CMP_W'(1)) < CMP_W'(i_width);
    assign last_row   = !((CMP_W'(r_row) + CMP_W'(1)) < CMP_W'(i_height));
    assign width_is_1 = (i_width == DIM_W'(1));
    assign width_is_2 = (i_width == DIM_W'(2));

    // up and up-right come from the read data or from a forwarded pixel
    assign cur_up = r_up_mem ? r_rd_b : r_up_q;
    assign cur_ur = r_ur_mem ? r_rd_a : r_ur_q;

    // distances to the neighbors that lie inside the frame
    always_comb begin
        add_c = '0;
        if (has_left) begin
            add_c = add_c + ADD_W'(sq_dist(i_pix, r_left));
        end
        if (has_up && has_left) begin
            add_c = add_c + ADD_W'(sq_dist(i_pix, r_upleft));
        end
        if (has_up) begin
            add_c = add_c + ADD_W'(sq_dist(i_pix, cur_up));
        end
        if (has_up && has_right) begin
            add_c = add_c + ADD_W'(sq_dist(i_pix, cur_ur));
        end
    end

    // read ahead: col+2 inside a row, columns 0 and 1 at the end of a row
    assign rd_a_addr = has_right ? (r_col + COL_W'(2)) : COL_W'(1);
    assign rd_b_en   = i_accept && !has_right && !width_is_1;

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_mem[r_col] <= i_pix;
            r_rd_a       <= r_mem[rd_a_addr];
        end
        if (rd_b_en) begin
            r_rd_b <= r_mem[COL_W'(0)];
        end
    end

    // next raster position and neighbor registers
    always_comb begin
        n_col    = r_col;
        n_row    = r_row;
        n_left   = r_left;
        n_upleft = r_upleft;
        n_up_q   = r_up_q;
        n_ur_q   = r_ur_q;
        n_up_mem = r_up_mem;
        n_ur_mem = r_ur_mem;
        if (i_accept) begin
            n_left   = i_pix;
            n_upleft = cur_up;
            if (has_right) begin
                n_col    = r_col + COL_W'(1);
                n_up_q   = cur_ur;
                n_up_mem = 1'b0;
                n_ur_mem = 1'b1;
            end else begin
                n_col = '0;
                n_row = last_row ? '0 : (r_row + ROW_W'(1));
                // entries written by this very pixel are forwarded
                if (width_is_1) begin
                    n_up_q   = i_pix;
                    n_up_mem = 1'b0;
                end else begin
                    n_up_mem = 1'b1;
                end
                if (width_is_2) begin
                    n_ur_q   = i_pix;
                    n_ur_mem = 1'b0;
                end else begin
                    n_ur_mem = 1'b1;
                end
            end
        end
    end

    assign sum_next = r_sum + SUM_W'(r_add);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_col      <= '0;
            r_row      <= '0;
            r_up_mem   <= 1'b0;
            r_ur_mem   <= 1'b0;
            r_add_v    <= 1'b0;
            r_add_last <= 1'b0;
            r_sum      <= '0;
            r_done_v   <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_up_mem   <= n_up_mem;
            r_ur_mem   <= n_ur_mem;
            r_add_v    <= i_accept;
            r_add_last <= i_accept && !has_right && last_row;
            r_done_v   <= 1'b0;
            if (r_add_v) begin
                if (r_add_last) begin
                    r_sum    <= '0;
                    r_done_v <= 1'b1;
                end else begin
                    r_sum <= sum_next;
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_left   <= n_left;
        r_upleft <= n_upleft;
        r_up_q   <= n_up_q;
        r_ur_q   <= n_ur_q;
        if (i_accept) begin
            r_add <= add_c;
        end
        if (r_add_v && r_add_last) begin
            r_done_sum <= sum_next;
        end
    end

    assign o_done.valid = r_done_v;
    assign o_done.sum   = r_done_sum;
    assign o_busy       = (r_add_v && r_add_last) || r_done_v;

    `NCB_ASSERT(a_col_in_row, i_clk, i_rst_n, (CMP_W'(r_col) < CMP_W'(i_width)), "column beyond width")
    `NCB_ASSERT_NEXT(a_last_gives_done, i_clk, i_rst_n, (r_add_v && r_add_last && !i_restart), r_done_v, "frame end lost")
    `NCB_ASSERT(a_done_at_origin, i_clk, i_rst_n, r_done_v |-> ((r_col == '0) && (r_row == '0)), "frame end not at origin")

endmodule

`default_nettype wire

>>> sv/ncb_div.sv
// Beta divider: floor(N * 2^FRACTION_BITS / (2 * sum)), one quotient bit per
// cycle, with saturation to 48 bits. Depends on ncb_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ncb_div #(
    parameter int FRACTION_BITS = ncb_pkg::DEF_FRACTION_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ncb_pkg::t_frame_done      i_start,
    input  logic [ncb_pkg::NUM_W-1:0] i_num,
    input  logic                      i_take,
    output ncb_pkg::t_div_status      o_status
);
    import ncb_pkg::*;

    localparam int STEPS  = NUM_W + FRACTION_BITS;
    localparam int STEP_W = $clog2(STEPS);
    localparam int DEN_W  = SUM_W + 1;
    localparam int REM_W  = SUM_W + 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_div_state;

    t_div_state        r_state;
    logic [STEP_W-1:0] r_step;
    logic [REM_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [NUM_W-1:0]  r_num;
    logic [BETA_W-1:0] r_quo;
    logic              r_sat;
    logic [SUM_W-1:0]  r_sum;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  rem_diff;
    logic              q_bit;

    // one restoring step: bring down the next dividend bit
    assign rem_sh   = {r_rem[REM_W-2:0], r_num[NUM_W-1]};
    assign q_bit    = (rem_sh >= REM_W'(r_den));
    assign rem_diff = rem_sh - REM_W'(r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_sat   <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start.valid) begin
                        r_sum   <= i_start.sum;
                        r_den   <= {i_start.sum, 1'b0};
                        r_num   <= i_num;
                        r_rem   <= '0;
                        r_quo   <= '0;
                        r_sat   <= 1'b0;
                        r_step  <= '0;
                        // zero sum: beta is zero, nothing to divide
                        r_state <= (i_start.sum == '0) ? ST_DONE : ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_rem  <= q_bit ? rem_diff : rem_sh;
                    r_quo  <= {r_quo[BETA_W-2:0], q_bit};
                    r_sat  <= r_sat | r_quo[BETA_W-1];
                    r_num  <= {r_num[NUM_W-2:0], 1'b0};
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(STEPS - 1)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (i_take) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_status.idle        = (r_state == ST_IDLE);
    assign o_status.done        = (r_state == ST_DONE);
    assign o_status.result.beta = r_sat ? '1 : r_quo;
    assign o_status.result.sum  = r_sum;
    assign o_status.result.sat  = r_sat;

    `NCB_ASSERT(a_start_when_idle, i_clk, i_rst_n, i_start.valid |-> (r_state == ST_IDLE), "frame end while divider busy")
    `NCB_ASSERT(a_run_den_nonzero, i_clk, i_rst_n, (r_state == ST_RUN) |-> (r_den != '0), "division by zero")
    `NCB_ASSERT_NEXT(a_done_holds, i_clk, i_rst_n, ((r_state == ST_DONE) && !i_take), ((r_state == ST_DONE) && $stable(r_quo) && $stable(r_sat)), "result changed before taken")

endmodule

`default_nettype wire

>>> sv/neighbour_contrast_beta_core.sv
// Top level of the neighbor contrast beta core: APB registers, frame constant N,
// output register. Depends on ncb_pkg, ncb_if, ncb_front and ncb_div.
//
//   channel   dir  handshake       payload
//   i_pix     in   valid/ready     channel_0, channel_1, channel_2 (8b each)
//   o_res     out  valid/ready     beta_value (48b), difference_sum (48b), beta_saturated
//   apb       in   psel/penable    paddr 0: image_width, 4: image_height (12b)
//
// One pixel per cycle inside a frame. The last pixel starts the divider,
// NUM_W + FRACTION_BITS steps (58 at the defaults), one quotient bit per cycle.
// The output register loads once the divider is done; a zero sum skips the steps.
// Input ready is low meanwhile, and while a result waits on a full output reg.
// Synchronous active-low reset; the line buffer needs no clearing pass.
// A register write restarts the frame.
`timescale 1ns / 1ps
`default_nettype none

module neighbour_contrast_beta_core #(
    parameter int MAX_WIDTH     = ncb_pkg::DEF_MAX_WIDTH,
    parameter int FRACTION_BITS = ncb_pkg::DEF_FRACTION_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    ncb_pix_if.sink                        i_pix,
    ncb_res_if.source                      o_res,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ncb_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ncb_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ncb_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import ncb_pkg::*;

    logic [DIM_W-1:0]   r_width;
    logic [DIM_W-1:0]   r_height;
    logic [DIM_W-1:0]   width_c;
    logic [DIM_W-1:0]   height_c;
    logic [2*DIM_W-1:0] r_wh;
    logic [NUM_W-1:0]   wh_sum;
    logic [NUM_W-1:0]   r_num;
    logic               cfg_wr;
    logic               pix_acc;
    logic               front_busy;
    t_frame_done        frame_done;
    t_div_status        div_st;
    logic               div_take;
    logic               r_out_valid;
    t_result            r_out;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_IMAGE_WIDTH:  r_width  <= pwdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT: r_height <= pwdata[DIM_W-1:0];
                default:          r_width  <= r_width;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(r_width);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(r_height);
            default:          prdata = '0;
        endcase
    end

    // dimensions in use, clamped to the legal range
    always_comb begin
        if (r_width == '0) begin
            width_c = DIM_W'(1);
        end else if (int'(r_width) > MAX_WIDTH) begin
            width_c = DIM_W'(MAX_WIDTH);
        end else begin
            width_c = r_width;
        end
        if (r_height == '0) begin
            height_c = DIM_W'(1);
        end else if (int'(r_height) > MAX_HEIGHT) begin
            height_c = DIM_W'(MAX_HEIGHT);
        end else begin
            height_c = r_height;
        end
    end

    // N = 4wh - 3w - 3h + 2, two register stages
    assign wh_sum = NUM_W'(width_c) + NUM_W'(height_c);

    always_ff @(posedge i_clk) begin
        r_wh  <= (2*DIM_W)'(width_c) * (2*DIM_W)'(height_c);
        r_num <= (NUM_W'(r_wh) << 2) + NUM_W'(2) - (wh_sum << 1) - wh_sum;
    end

    // pixel front end
    assign i_pix.ready = !front_busy && div_st.idle;
    assign pix_acc     = i_pix.valid && i_pix.ready;

    ncb_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (cfg_wr),
        .i_width   (width_c),
        .i_height  (height_c),
        .i_accept  (pix_acc),
        .i_pix     ({i_pix.channel_2, i_pix.channel_1, i_pix.channel_0}),
        .o_done    (frame_done),
        .o_busy    (front_busy)
    );

    ncb_div #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (frame_done),
        .i_num    (r_num),
        .i_take   (div_take),
        .o_status (div_st)
    );

    // output register
    assign div_take = div_st.done && (!r_out_valid || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (div_take) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_take) begin
            r_out <= div_st.result;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.beta_value     = r_out.beta;
    assign o_res.difference_sum = r_out.sum;
    assign o_res.beta_saturated = r_out.sat;

endmodule

`default_nettype wire
